// ===== rtl/ucm_pkg.sv =====
// ----------------------------------------------------------------------------
// ucm_pkg
// Shared types, opcodes and table-entry match helpers for the case mapper.
// ----------------------------------------------------------------------------
package ucm_pkg;

    localparam int CP_W = 21;

    localparam logic OP_UPPER = 1'b0;
    localparam logic OP_LOWER = 1'b1;

    // Outcome of a page table search: absolute value or signed delta.
    typedef struct packed {
        logic        hit;
        logic        fixed;
        logic [15:0] value;
    } ucm_hit_t;

    function automatic logic step_ok(logic [7:0] diff, logic [4:0] stride);
        logic ok;
        begin
            case (stride)
                5'd1:    ok = 1'b1;
                5'd2:    ok = !diff[0];
                5'd3:    ok = (diff == 8'd0) || (diff == 8'd3) || (diff == 8'd6)
                              || (diff == 8'd9);
                5'd4:    ok = (diff[1:0] == 2'd0);
                5'd5:    ok = (diff == 8'd0) || (diff == 8'd5) || (diff == 8'd10);
                5'd6:    ok = (diff == 8'd0) || (diff == 8'd6) || (diff == 8'd12);
                5'd16:   ok = (diff[3:0] == 4'd0);
                default: ok = 1'b0;
            endcase
            return ok;
        end
    endfunction

    // Delta entry: range lo..hi, stride, signed offset.
    function automatic ucm_hit_t ent_d(ucm_hit_t r, logic [7:0] lsb, logic [7:0] lo,
                                       logic [7:0] hi, logic [4:0] stride,
                                       logic signed [15:0] delta);
        logic [7:0] diff;
        ucm_hit_t   o;
        begin
            diff = lsb - lo;
            o    = r;
            if (!r.hit && (lsb >= lo) && (lsb <= hi) && step_ok(diff, stride)) begin
                o.hit   = 1'b1;
                o.fixed = 1'b0;
                o.value = delta;
            end
            return o;
        end
    endfunction

    // Fixed entry: one low byte, absolute result.
    function automatic ucm_hit_t ent_f(ucm_hit_t r, logic [7:0] lsb, logic [7:0] lo,
                                       logic [15:0] val);
        ucm_hit_t o;
        begin
            o = r;
            if (!r.hit && (lsb == lo)) begin
                o.hit   = 1'b1;
                o.fixed = 1'b1;
                o.value = val;
            end
            return o;
        end
    endfunction

endpackage

// ===== rtl/ucm_lookup.sv =====
// ----------------------------------------------------------------------------
// ucm_lookup
// Per-page range tables, first match wins; forms the mapped code point.
// ----------------------------------------------------------------------------
module ucm_lookup
    import ucm_pkg::*;
(
    input  logic            opcode,
    input  logic [CP_W-1:0] code_point,
    output logic [CP_W-1:0] mapped_code_point,
    output logic            was_changed
);

    logic [7:0]      lsb;
    logic [8:0]      key;
    ucm_hit_t        r;
    logic [CP_W-1:0] res;

    assign lsb = code_point[7:0];
    assign key = {opcode, code_point[15:8]};

    always_comb begin
        r = '0;
        if (code_point[20:16] == 5'd0) begin
            case (key)
                {OP_UPPER, 8'h00}: begin
                    r = ent_d(r, lsb, 8'h61, 8'h7A, 5'd1, -16'sd32);
                    r = ent_d(r, lsb, 8'hE0, 8'hF6, 5'd1, -16'sd32);
                    r = ent_d(r, lsb, 8'hF8, 8'hFE, 5'd1, -16'sd32);
                    r = ent_f(r, lsb, 8'hFF, 16'h0178);
                end
                {OP_UPPER, 8'h01}: begin
                    r = ent_d(r, lsb, 8'h01, 8'h2F, 5'd2, -16'sd1);
                    r = ent_d(r, lsb, 8'h33, 8'h37, 5'd2, -16'sd1);
                    r = ent_d(r, lsb, 8'h3A, 8'h48, 5'd2, -16'sd1);
                    r = ent_d(r, lsb, 8'h4B, 8'h77, 5'd2, -16'sd1);
                    r = ent_d(r, lsb, 8'h7A, 8'h7E, 5'd2, -16'sd1);
                    r = ent_f(r, lsb, 8'h80, 16'h0243);
                    r = ent_d(r, lsb, 8'h83, 8'h85, 5'd2, -16'sd1);
                    r = ent_d(r, lsb, 8'h88, 8'h8C, 5'd4, -16'sd1);
                    r = ent_f(r, lsb, 8'h92, 16'h0191);
                    r = ent_f(r, lsb, 8'h95, 16'h01F6);
                    r = ent_f(r, lsb, 8'h99, 16'h0198);
                    r = ent_f(r, lsb, 8'h9A, 16'h023D);
                    r = ent_f(r, lsb, 8'h9E, 16'h0220);
                    r = ent_d(r, lsb, 8'hA1, 8'hA5, 5'd2, -16'sd1);
                    r = ent_d(r, lsb, 8'hA8, 8'hAD, 5'd5, -16'sd1);
                    r = ent_f(r, lsb, 8'hB0, 16'h01AF);
                    r = ent_d(r, lsb, 8'hB4, 8'hB6, 5'd2, -16'sd1);
                    r = ent_d(r, lsb, 8'hB9, 8'hBD, 5'd4, -16'sd1);
                    r = ent_f(r, lsb, 8'hBF, 16'h01F7);
                    r = ent_d(r, lsb, 8'hC6, 8'hCC, 5'd3, -16'sd2);
                    r = ent_d(r, lsb, 8'hCE, 8'hDC, 5'd2, -16'sd1);
                    r = ent_f(r, lsb, 8'hDD, 16'h018E);
                    r = ent_f(r, lsb, 8'hDF, 16'h01DE);
                    r = ent_d(r, lsb, 8'hE1, 8'hEF, 5'd2, -16'sd1);
                    r = ent_f(r, lsb, 8'hF3, 16'h01F1);
                    r = ent_f(r, lsb, 8'hF5, 16'h01F4);
                    r = ent_d(r, lsb, 8'hF9, 8'hFF, 5'd2, -16'sd1);
                end
                {OP_UPPER, 8'h02}: begin
                    r = ent_d(r, lsb, 8'h01, 8'h1F, 5'd2, -16'sd1);
                    r = ent_d(r, lsb, 8'h23, 8'h33, 5'd2, -16'sd1);
                    r = ent_d(r, lsb, 8'h3C, 8'h42, 5'd6, -16'sd1);
                    r = ent_f(r, lsb, 8'h43, 16'h0180);
                    r = ent_d(r, lsb, 8'h47, 8'h4F, 5'd2, -16'sd1);
                    r = ent_f(r, lsb, 8'h50, 16'h2C6F);
                    r = ent_f(r, lsb, 8'h51, 16'h2C6D);
                    r = ent_f(r, lsb, 8'h53, 16'h0181);
                    r = ent_f(r, lsb, 8'h54, 16'h0186);
                    r = ent_d(r, lsb, 8'h56, 8'h57, 5'd1, -16'sd205);
                    r = ent_f(r, lsb, 8'h59, 16'h018F);
                    r = ent_f(r, lsb, 8'h5B, 16'h0190);
                    r = ent_f(r, lsb, 8'h60, 16'h0193);
                    r = ent_f(r, lsb, 8'h63, 16'h0194);
                    r = ent_f(r, lsb, 8'h68, 16'h0197);
                    r = ent_f(r, lsb, 8'h69, 16'h0196);
                    r = ent_f(r, lsb, 8'h6B, 16'h2C62);
                    r = ent_f(r, lsb, 8'h6F, 16'h019C);
                    r = ent_f(r, lsb, 8'h71, 16'h2C6E);
                    r = ent_f(r, lsb, 8'h72, 16'h019D);
                    r = ent_f(r, lsb, 8'h75, 16'h019F);
                    r = ent_f(r, lsb, 8'h7D, 16'h2C64);
                    r = ent_d(r, lsb, 8'h80, 8'h83, 5'd3, -16'sd218);
                    r = ent_f(r, lsb, 8'h88, 16'h01AE);
                    r = ent_f(r, lsb, 8'h89, 16'h0244);
                    r = ent_d(r, lsb, 8'h8A, 8'h8B, 5'd1, -16'sd217);
                    r = ent_f(r, lsb, 8'h8C, 16'h0245);
                    r = ent_f(r, lsb, 8'h92, 16'h01B7);
                end
                {OP_UPPER, 8'h03}: begin
                    r = ent_d(r, lsb, 8'h71, 8'h73, 5'd2, -16'sd1);
                    r = ent_f(r, lsb, 8'h77, 16'h0376);
                    r = ent_d(r, lsb, 8'h7B, 8'h7D, 5'd1, 16'sd130);
                    r = ent_f(r, lsb, 8'hAC, 16'h0386);
                    r = ent_d(r, lsb, 8'hAD, 8'hAF, 5'd1, -16'sd37);
                    r = ent_d(r, lsb, 8'hB1, 8'hC1, 5'd1, -16'sd32);
                    r = ent_d(r, lsb, 8'hC3, 8'hC4, 5'd1, -16'sd32);
                    r = ent_d(r, lsb, 8'hC5, 8'hCB, 5'd1, -16'sd32);
                    r = ent_f(r, lsb, 8'hCC, 16'h038C);
                    r = ent_d(r, lsb, 8'hCD, 8'hCE, 5'd1, -16'sd63);
                    r = ent_f(r, lsb, 8'hD7, 16'h03CF);
                    r = ent_d(r, lsb, 8'hD9, 8'hEF, 5'd2, -16'sd1);
                    r = ent_f(r, lsb, 8'hF2, 16'h03F9);
                    r = ent_d(r, lsb, 8'hF8, 8'hFB, 5'd3, -16'sd1);
                end
                {OP_UPPER, 8'h04}: begin
                    r = ent_d(r, lsb, 8'h30, 8'h4F, 5'd1, -16'sd32);
                    r = ent_d(r, lsb, 8'h50, 8'h5F, 5'd1, -16'sd80);
                    r = ent_d(r, lsb, 8'h61, 8'h81, 5'd2, -16'sd1);
                    r = ent_f(r, lsb, 8'h8B, 16'h048A);
                    r = ent_d(r, lsb, 8'h8D, 8'hBF, 5'd2, -16'sd1);
                    r = ent_d(r, lsb, 8'hC2, 8'hCE, 5'd2, -16'sd1);
                    r = ent_f(r, lsb, 8'hCF, 16'h04C0);
                    r = ent_d(r, lsb, 8'hD1, 8'hFF, 5'd2, -16'sd1);
                end
                {OP_UPPER, 8'h05}: begin
                    r = ent_d(r, lsb, 8'h01, 8'h23, 5'd2, -16'sd1);
                    r = ent_d(r, lsb, 8'h61, 8'h86, 5'd1, -16'sd48);
                end
                {OP_UPPER, 8'h1D}: begin
                    r = ent_f(r, lsb, 8'h79, 16'hA77D);
                    r = ent_f(r, lsb, 8'h7D, 16'h2C63);
                end
                {OP_UPPER, 8'h1E}: begin
                    r = ent_d(r, lsb, 8'h01, 8'h95, 5'd2, -16'sd1);
                    r = ent_d(r, lsb, 8'hA1, 8'hFF, 5'd2, -16'sd1);
                end
                {OP_UPPER, 8'h1F}: begin
                    r = ent_d(r, lsb, 8'h00, 8'h07, 5'd1, 16'sd8);
                    r = ent_d(r, lsb, 8'h10, 8'h15, 5'd1, 16'sd8);
                    r = ent_d(r, lsb, 8'h20, 8'h27, 5'd1, 16'sd8);
                    r = ent_d(r, lsb, 8'h30, 8'h37, 5'd1, 16'sd8);
                    r = ent_d(r, lsb, 8'h40, 8'h45, 5'd1, 16'sd8);
                    r = ent_d(r, lsb, 8'h51, 8'h57, 5'd2, 16'sd8);
                    r = ent_d(r, lsb, 8'h60, 8'h67, 5'd1, 16'sd8);
                    r = ent_d(r, lsb, 8'h70, 8'h71, 5'd1, 16'sd74);
                    r = ent_d(r, lsb, 8'h72, 8'h75, 5'd1, 16'sd86);
                    r = ent_d(r, lsb, 8'h76, 8'h77, 5'd1, 16'sd100);
                    r = ent_d(r, lsb, 8'h78, 8'h79, 5'd1, 16'sd128);
                    r = ent_d(r, lsb, 8'h7A, 8'h7B, 5'd1, 16'sd112);
                    r = ent_d(r, lsb, 8'h7C, 8'h7D, 5'd1, 16'sd126);
                    r = ent_d(r, lsb, 8'h80, 8'h87, 5'd1, 16'sd8);
                    r = ent_d(r, lsb, 8'h90, 8'h97, 5'd1, 16'sd8);
                    r = ent_d(r, lsb, 8'hA0, 8'hA7, 5'd1, 16'sd8);
                    r = ent_d(r, lsb, 8'hB0, 8'hB1, 5'd1, 16'sd8);
                    r = ent_d(r, lsb, 8'hB3, 8'hC3, 5'd16, 16'sd9);
                    r = ent_d(r, lsb, 8'hD0, 8'hD1, 5'd1, 16'sd8);
                    r = ent_d(r, lsb, 8'hE0, 8'hE1, 5'd1, 16'sd8);
                    r = ent_f(r, lsb, 8'hE5, 16'h1FEC);
                    r = ent_f(r, lsb, 8'hF3, 16'h1FFC);
                end
                {OP_UPPER, 8'h21}: begin
                    r = ent_f(r, lsb, 8'h4E, 16'h2132);
                    r = ent_d(r, lsb, 8'h70, 8'h7F, 5'd1, -16'sd16);
                    r = ent_f(r, lsb, 8'h84, 16'h2183);
                end
                {OP_UPPER, 8'h24}: begin
                    r = ent_d(r, lsb, 8'hD0, 8'hE9, 5'd1, -16'sd26);
                end
                {OP_UPPER, 8'h2C}: begin
                    r = ent_d(r, lsb, 8'h30, 8'h5E, 5'd1, -16'sd48);
                    r = ent_f(r, lsb, 8'h61, 16'h2C60);
                    r = ent_f(r, lsb, 8'h65, 16'h023A);
                    r = ent_f(r, lsb, 8'h66, 16'h023E);
                    r = ent_d(r, lsb, 8'h68, 8'h6C, 5'd2, -16'sd1);
                    r = ent_d(r, lsb, 8'h73, 8'h76, 5'd3, -16'sd1);
                    r = ent_d(r, lsb, 8'h81, 8'hE3, 5'd2, -16'sd1);
                end
                {OP_UPPER, 8'h2D}: begin
                    r = ent_d(r, lsb, 8'h00, 8'h25, 5'd1, -16'sd7264);
                end
                {OP_UPPER, 8'hA6}: begin
                    r = ent_d(r, lsb, 8'h41, 8'h5F, 5'd2, -16'sd1);
                    r = ent_d(r, lsb, 8'h63, 8'h6D, 5'd2, -16'sd1);
                    r = ent_d(r, lsb, 8'h81, 8'h97, 5'd2, -16'sd1);
                end
                {OP_UPPER, 8'hA7}: begin
                    r = ent_d(r, lsb, 8'h23, 8'h2F, 5'd2, -16'sd1);
                    r = ent_d(r, lsb, 8'h33, 8'h6F, 5'd2, -16'sd1);
                    r = ent_d(r, lsb, 8'h7A, 8'h7C, 5'd2, -16'sd1);
                    r = ent_d(r, lsb, 8'h7F, 8'h87, 5'd2, -16'sd1);
                    r = ent_f(r, lsb, 8'h8C, 16'hA78B);
                end
                {OP_UPPER, 8'hFF}: begin
                    r = ent_d(r, lsb, 8'h41, 8'h5A, 5'd1, -16'sd32);
                end
                {OP_LOWER, 8'h00}: begin
                    r = ent_d(r, lsb, 8'h41, 8'h5A, 5'd1, 16'sd32);
                    r = ent_d(r, lsb, 8'hC0, 8'hD6, 5'd1, 16'sd32);
                    r = ent_d(r, lsb, 8'hD8, 8'hDE, 5'd1, 16'sd32);
                end
                {OP_LOWER, 8'h01}: begin
                    r = ent_d(r, lsb, 8'h00, 8'h2E, 5'd2, 16'sd1);
                    r = ent_d(r, lsb, 8'h32, 8'h36, 5'd2, 16'sd1);
                    r = ent_d(r, lsb, 8'h39, 8'h47, 5'd2, 16'sd1);
                    r = ent_d(r, lsb, 8'h4A, 8'h76, 5'd2, 16'sd1);
                    r = ent_f(r, lsb, 8'h78, 16'h00FF);
                    r = ent_d(r, lsb, 8'h79, 8'h7D, 5'd2, 16'sd1);
                    r = ent_f(r, lsb, 8'h80, 16'h0243);
                    r = ent_f(r, lsb, 8'h81, 16'h0253);
                    r = ent_d(r, lsb, 8'h82, 8'h84, 5'd2, 16'sd1);
                    r = ent_f(r, lsb, 8'h86, 16'h0254);
                    r = ent_d(r, lsb, 8'h87, 8'h8B, 5'd4, 16'sd1);
                    r = ent_d(r, lsb, 8'h89, 8'h89, 5'd1, 16'sd205);
                    r = ent_f(r, lsb, 8'h8A, 16'h0257);
                    r = ent_f(r, lsb, 8'h8E, 16'h01DD);
                    r = ent_f(r, lsb, 8'h8F, 16'h0259);
                    r = ent_f(r, lsb, 8'h90, 16'h025B);
                    r = ent_f(r, lsb, 8'h91, 16'h0192);
                    r = ent_f(r, lsb, 8'h93, 16'h0260);
                    r = ent_f(r, lsb, 8'h94, 16'h0263);
                    r = ent_f(r, lsb, 8'h96, 16'h0269);
                    r = ent_f(r, lsb, 8'h97, 16'h0268);
                    r = ent_f(r, lsb, 8'h98, 16'h0199);
                    r = ent_f(r, lsb, 8'h9C, 16'h026F);
                    r = ent_f(r, lsb, 8'h9D, 16'h0272);
                    r = ent_f(r, lsb, 8'h9F, 16'h0275);
                    r = ent_d(r, lsb, 8'hA0, 8'hA4, 5'd2, 16'sd1);
                    r = ent_d(r, lsb, 8'hA6, 8'hA9, 5'd3, 16'sd218);
                    r = ent_f(r, lsb, 8'hAE, 16'h0288);
                    r = ent_d(r, lsb, 8'hA7, 8'hAC, 5'd5, 16'sd1);
                    r = ent_f(r, lsb, 8'hAF, 16'h01B0);
                    r = ent_d(r, lsb, 8'hB1, 8'hB2, 5'd1, 16'sd217);
                    r = ent_d(r, lsb, 8'hB3, 8'hB5, 5'd2, 16'sd1);
                    r = ent_f(r, lsb, 8'hB7, 16'h0292);
                    r = ent_d(r, lsb, 8'hB8, 8'hBC, 5'd4, 16'sd1);
                    r = ent_d(r, lsb, 8'hC4, 8'hCA, 5'd3, 16'sd2);
                    r = ent_d(r, lsb, 8'hCD, 8'hDB, 5'd2, 16'sd1);
                    r = ent_f(r, lsb, 8'hDE, 16'h01DF);
                    r = ent_d(r, lsb, 8'hE0, 8'hEE, 5'd2, 16'sd1);
                    r = ent_f(r, lsb, 8'hF1, 16'h01F3);
                    r = ent_f(r, lsb, 8'hF4, 16'h01F5);
                    r = ent_f(r, lsb, 8'hF6, 16'h0195);
                    r = ent_f(r, lsb, 8'hF7, 16'h01BF);
                    r = ent_d(r, lsb, 8'hF8, 8'hFE, 5'd2, 16'sd1);
                end
                {OP_LOWER, 8'h02}: begin
                    r = ent_d(r, lsb, 8'h00, 8'h1E, 5'd2, 16'sd1);
                    r = ent_f(r, lsb, 8'h20, 16'h019E);
                    r = ent_d(r, lsb, 8'h22, 8'h32, 5'd2, 16'sd1);
                    r = ent_f(r, lsb, 8'h3A, 16'h2C65);
                    r = ent_d(r, lsb, 8'h3B, 8'h41, 5'd6, 16'sd1);
                    r = ent_f(r, lsb, 8'h3D, 16'h019A);
                    r = ent_f(r, lsb, 8'h3E, 16'h2C66);
                    r = ent_f(r, lsb, 8'h43, 16'h0180);
                    r = ent_f(r, lsb, 8'h44, 16'h0289);
                    r = ent_f(r, lsb, 8'h45, 16'h028C);
                    r = ent_d(r, lsb, 8'h46, 8'h4E, 5'd2, 16'sd1);
                end
                {OP_LOWER, 8'h03}: begin
                    r = ent_d(r, lsb, 8'h70, 8'h72, 5'd2, 16'sd1);
                    r = ent_f(r, lsb, 8'h76, 16'h0377);
                    r = ent_f(r, lsb, 8'h86, 16'h03AC);
                    r = ent_d(r, lsb, 8'h88, 8'h8A, 5'd1, 16'sd37);
                    r = ent_f(r, lsb, 8'h8C, 16'h03CC);
                    r = ent_d(r, lsb, 8'h8E, 8'h8F, 5'd1, 16'sd63);
                    r = ent_d(r, lsb, 8'h91, 8'hA1, 5'd1, 16'sd32);
                    r = ent_d(r, lsb, 8'hA3, 8'hA4, 5'd1, 16'sd32);
                    r = ent_d(r, lsb, 8'hA5, 8'hAB, 5'd1, 16'sd32);
                    r = ent_f(r, lsb, 8'hCF, 16'h03D7);
                    r = ent_d(r, lsb, 8'hD8, 8'hEE, 5'd2, 16'sd1);
                    r = ent_f(r, lsb, 8'hF9, 16'h03F2);
                    r = ent_d(r, lsb, 8'hF7, 8'hFA, 5'd3, 16'sd1);
                    r = ent_d(r, lsb, 8'hFD, 8'hFF, 5'd1, -16'sd130);
                end
                {OP_LOWER, 8'h04}: begin
                    r = ent_d(r, lsb, 8'h10, 8'h2F, 5'd1, 16'sd32);
                    r = ent_d(r, lsb, 8'h00, 8'h0F, 5'd1, 16'sd80);
                    r = ent_d(r, lsb, 8'h60, 8'h80, 5'd2, 16'sd1);
                    r = ent_f(r, lsb, 8'h8A, 16'h048B);
                    r = ent_d(r, lsb, 8'h8C, 8'hBE, 5'd2, 16'sd1);
                    r = ent_d(r, lsb, 8'hC1, 8'hCD, 5'd2, 16'sd1);
                    r = ent_f(r, lsb, 8'hC0, 16'h04CF);
                    r = ent_d(r, lsb, 8'hD0, 8'hFE, 5'd2, 16'sd1);
                end
                {OP_LOWER, 8'h05}: begin
                    r = ent_d(r, lsb, 8'h00, 8'h22, 5'd2, 16'sd1);
                    r = ent_d(r, lsb, 8'h31, 8'h56, 5'd1, 16'sd48);
                end
                {OP_LOWER, 8'h10}: begin
                    r = ent_d(r, lsb, 8'hA0, 8'hC5, 5'd1, 16'sd7264);
                end
                {OP_LOWER, 8'h1E}: begin
                    r = ent_d(r, lsb, 8'h00, 8'h94, 5'd2, 16'sd1);
                    r = ent_d(r, lsb, 8'hA0, 8'hFE, 5'd2, 16'sd1);
                end
                {OP_LOWER, 8'h1F}: begin
                    r = ent_d(r, lsb, 8'h08, 8'h0F, 5'd1, -16'sd8);
                    r = ent_d(r, lsb, 8'h18, 8'h1D, 5'd1, -16'sd8);
                    r = ent_d(r, lsb, 8'h28, 8'h2F, 5'd1, -16'sd8);
                    r = ent_d(r, lsb, 8'h38, 8'h3F, 5'd1, -16'sd8);
                    r = ent_d(r, lsb, 8'h48, 8'h4D, 5'd1, -16'sd8);
                    r = ent_d(r, lsb, 8'h59, 8'h5F, 5'd2, -16'sd8);
                    r = ent_d(r, lsb, 8'h68, 8'h6F, 5'd1, -16'sd8);
                    r = ent_d(r, lsb, 8'hBA, 8'hBB, 5'd1, -16'sd74);
                    r = ent_d(r, lsb, 8'hC8, 8'hCB, 5'd1, -16'sd86);
                    r = ent_d(r, lsb, 8'hDA, 8'hDB, 5'd1, -16'sd100);
                    r = ent_d(r, lsb, 8'hF8, 8'hF9, 5'd1, -16'sd128);
                    r = ent_d(r, lsb, 8'hEA, 8'hEB, 5'd1, -16'sd112);
                    r = ent_d(r, lsb, 8'hFA, 8'hFB, 5'd1, -16'sd126);
                    r = ent_d(r, lsb, 8'h88, 8'h8F, 5'd1, -16'sd8);
                    r = ent_d(r, lsb, 8'h98, 8'h9F, 5'd1, -16'sd8);
                    r = ent_d(r, lsb, 8'hA8, 8'hAF, 5'd1, -16'sd8);
                    r = ent_d(r, lsb, 8'hB8, 8'hB9, 5'd1, -16'sd8);
                    r = ent_f(r, lsb, 8'hBB, 16'h1F71);
                    r = ent_d(r, lsb, 8'hBC, 8'hCC, 5'd16, -16'sd9);
                    r = ent_d(r, lsb, 8'hD8, 8'hD9, 5'd1, -16'sd8);
                    r = ent_d(r, lsb, 8'hE8, 8'hE9, 5'd1, -16'sd8);
                    r = ent_f(r, lsb, 8'hEC, 16'h1FE5);
                    r = ent_f(r, lsb, 8'hFC, 16'h1FF3);
                end
                {OP_LOWER, 8'h21}: begin
                    r = ent_f(r, lsb, 8'h32, 16'h214E);
                    r = ent_d(r, lsb, 8'h60, 8'h6F, 5'd1, 16'sd16);
                    r = ent_f(r, lsb, 8'h83, 16'h2184);
                end
                {OP_LOWER, 8'h24}: begin
                    r = ent_d(r, lsb, 8'hB6, 8'hCF, 5'd1, 16'sd26);
                end
                {OP_LOWER, 8'h2C}: begin
                    r = ent_d(r, lsb, 8'h00, 8'h2E, 5'd1, 16'sd48);
                    r = ent_f(r, lsb, 8'h60, 16'h2C61);
                    r = ent_d(r, lsb, 8'h67, 8'h6B, 5'd2, 16'sd1);
                    r = ent_d(r, lsb, 8'h72, 8'h75, 5'd3, 16'sd1);
                    r = ent_d(r, lsb, 8'h80, 8'hE2, 5'd2, 16'sd1);
                    r = ent_f(r, lsb, 8'h62, 16'h026B);
                    r = ent_f(r, lsb, 8'h63, 16'h1D7D);
                    r = ent_f(r, lsb, 8'h64, 16'h027D);
                    r = ent_f(r, lsb, 8'h6D, 16'h0251);
                    r = ent_f(r, lsb, 8'h6E, 16'h0271);
                    r = ent_f(r, lsb, 8'h6F, 16'h0250);
                end
                {OP_LOWER, 8'hA6}: begin
                    r = ent_d(r, lsb, 8'h40, 8'h5E, 5'd2, 16'sd1);
                    r = ent_d(r, lsb, 8'h62, 8'h6C, 5'd2, 16'sd1);
                    r = ent_d(r, lsb, 8'h80, 8'h96, 5'd2, 16'sd1);
                end
                {OP_LOWER, 8'hA7}: begin
                    r = ent_d(r, lsb, 8'h22, 8'h2E, 5'd2, 16'sd1);
                    r = ent_d(r, lsb, 8'h32, 8'h6E, 5'd2, 16'sd1);
                    r = ent_d(r, lsb, 8'h79, 8'h7B, 5'd2, 16'sd1);
                    r = ent_f(r, lsb, 8'h7D, 16'h1D79);
                    r = ent_d(r, lsb, 8'h7E, 8'h86, 5'd2, 16'sd1);
                    r = ent_f(r, lsb, 8'h8B, 16'hA78C);
                end
                {OP_LOWER, 8'hFF}: begin
                    r = ent_d(r, lsb, 8'h21, 8'h3A, 5'd1, 16'sd32);
                end
                default: r = '0;
            endcase
        end
    end

    // Fixed entries give an absolute value; delta entries add sign-extended offset.
    always_comb begin
        if (!r.hit) begin
            res = code_point;
        end else if (r.fixed) begin
            res = {5'd0, r.value};
        end else begin
            res = code_point + {{(CP_W-16){r.value[15]}}, r.value};
        end
    end

    assign mapped_code_point = res;
    assign was_changed       = (res != code_point);

endmodule

// ===== rtl/unicode_case_mapper.sv =====
// Registers: an input register and a result register lie between input beat and result beat.
// Throughput: one beat per cycle unless m_ready stalls it; the table search is a single
//   pass of parallel range comparators feeding one 21-bit adder between the two registers.
// Reset: aresetn (synchronous, active low) empties both stages; payload is not reset.
// Stalls: each stage holds while the stage after it is full and not taken.
// ----------------------------------------------------------------------------
// unicode_case_mapper
// Simple case mapping of one code point per beat, to upper or to lower case.
// ----------------------------------------------------------------------------
module unicode_case_mapper
    import ucm_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_opcode,
    input  logic [CP_W-1:0] s_code_point,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [CP_W-1:0] m_mapped_code_point,
    output logic            m_was_changed
);

    // Input stage
    logic            in_vld_reg, in_vld_next;
    logic            in_op_reg;
    logic [CP_W-1:0] in_cp_reg;

    // Result stage
    logic            out_vld_reg, out_vld_next;
    logic [CP_W-1:0] out_cp_reg;
    logic            out_chg_reg;

    logic            out_free;
    logic            in_free;
    logic [CP_W-1:0] lk_cp;
    logic            lk_chg;

    // The result stage can take a beat when empty or being drained this cycle.
    assign out_free = !out_vld_reg || m_ready;
    assign in_free  = !in_vld_reg || out_free;
    assign s_ready  = in_free;

    ucm_lookup u_lookup (
        .opcode            (in_op_reg),
        .code_point        (in_cp_reg),
        .mapped_code_point (lk_cp),
        .was_changed       (lk_chg)
    );

    always_comb begin
        in_vld_next  = in_free ? s_valid : in_vld_reg;
        out_vld_next = out_free ? in_vld_reg : out_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload: loaded on transfer, no reset.
    always_ff @(posedge aclk) begin
        if (in_free && s_valid) begin
            in_op_reg <= s_opcode;
            in_cp_reg <= s_code_point;
        end
        if (out_free && in_vld_reg) begin
            out_cp_reg  <= lk_cp;
            out_chg_reg <= lk_chg;
        end
    end

    assign m_valid             = out_vld_reg;
    assign m_mapped_code_point = out_cp_reg;
    assign m_was_changed       = out_chg_reg;

`ifndef SYNTH
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid && !in_vld_reg)
        else $error("stages not empty after reset");
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !out_free) |=> in_vld_reg)
        else $error("input stage beat lost under stall");
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && out_free) |=> m_valid)
        else $error("result stage missed a beat");
`endif

endmodule

// ===== sim/unicode_case_mapper_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unicode_case_mapper_test
// Self-checking bench for the case mapper. A scoreboard predicts every
// result from its own copy of the per-page case tables; both channels are
// throttled at random.
// ----------------------------------------------------------------------------
module unicode_case_mapper_test;
    import ucm_pkg::*;

    typedef struct {
        logic            opcode;
        logic [CP_W-1:0] code_point;
        logic [CP_W-1:0] mapped;
        logic            changed;
    } case_result_t;

    // Scoreboard: holds the predicted mappings in beat order.
    class case_map_scoreboard;
        case_result_t    pending_maps[$];
        int              errors;
        // working state of one table search
        logic [CP_W-1:0] cp;
        logic [7:0]      lsb;
        logic [CP_W-1:0] res;
        bit              hit;

        // range entry: lo..hi at the given stride, signed offset added
        function void dlt(int lo, int hi, int stride, int delta);
            if (!hit && lsb >= lo && lsb <= hi && (lsb - lo) % stride == 0) begin
                hit = 1;
                res = CP_W'(int'(cp) + delta);
            end
        endfunction

        // single entry: one low byte, absolute answer
        function void fix(int lo, int val);
            if (!hit && lsb == lo) begin
                hit = 1;
                res = CP_W'(val);
            end
        endfunction

        function logic [CP_W-1:0] map_case(logic op, logic [CP_W-1:0] point);
            int pg;
            cp  = point;
            lsb = point[7:0];
            res = point;
            hit = 0;
            pg  = point >> 8;
            if (op == OP_UPPER) begin
                case (pg)
                    'h00: begin
                        dlt('h61,'h7A,1,-32); dlt('hE0,'hF6,1,-32); dlt('hF8,'hFE,1,-32);
                        fix('hFF,'h0178);
                    end
                    'h01: begin
                        dlt('h01,'h2F,2,-1); dlt('h33,'h37,2,-1); dlt('h3A,'h48,2,-1);
                        dlt('h4B,'h77,2,-1); dlt('h7A,'h7E,2,-1); fix('h80,'h0243);
                        dlt('h83,'h85,2,-1); dlt('h88,'h8C,4,-1); fix('h92,'h0191);
                        fix('h95,'h01F6); fix('h99,'h0198); fix('h9A,'h023D);
                        fix('h9E,'h0220); dlt('hA1,'hA5,2,-1); dlt('hA8,'hAD,5,-1);
                        fix('hB0,'h01AF); dlt('hB4,'hB6,2,-1); dlt('hB9,'hBD,4,-1);
                        fix('hBF,'h01F7); dlt('hC6,'hCC,3,-2); dlt('hCE,'hDC,2,-1);
                        fix('hDD,'h018E); fix('hDF,'h01DE); dlt('hE1,'hEF,2,-1);
                        fix('hF3,'h01F1); fix('hF5,'h01F4); dlt('hF9,'hFF,2,-1);
                    end
                    'h02: begin
                        dlt('h01,'h1F,2,-1); dlt('h23,'h33,2,-1); dlt('h3C,'h42,6,-1);
                        fix('h43,'h0180); dlt('h47,'h4F,2,-1); fix('h50,'h2C6F);
                        fix('h51,'h2C6D); fix('h53,'h0181); fix('h54,'h0186);
                        dlt('h56,'h57,1,'h0189-'h0256); fix('h59,'h018F); fix('h5B,'h0190);
                        fix('h60,'h0193); fix('h63,'h0194); fix('h68,'h0197);
                        fix('h69,'h0196); fix('h6B,'h2C62); fix('h6F,'h019C);
                        fix('h71,'h2C6E); fix('h72,'h019D); fix('h75,'h019F);
                        fix('h7D,'h2C64); dlt('h80,'h83,3,'h01A6-'h0280);
                        fix('h88,'h01AE); fix('h89,'h0244);
                        dlt('h8A,'h8B,1,'h01B1-'h028A); fix('h8C,'h0245); fix('h92,'h01B7);
                    end
                    'h03: begin
                        dlt('h71,'h73,2,-1); fix('h77,'h0376); dlt('h7B,'h7D,1,'h03FD-'h037B);
                        fix('hAC,'h0386); dlt('hAD,'hAF,1,'h0388-'h03AD);
                        dlt('hB1,'hC1,1,-32); dlt('hC3,'hC4,1,-32); dlt('hC5,'hCB,1,-32);
                        fix('hCC,'h038C); dlt('hCD,'hCE,1,-63); fix('hD7,'h03CF);
                        dlt('hD9,'hEF,2,-1); fix('hF2,'h03F9); dlt('hF8,'hFB,3,-1);
                    end
                    'h04: begin
                        dlt('h30,'h4F,1,-32); dlt('h50,'h5F,1,-80); dlt('h61,'h81,2,-1);
                        fix('h8B,'h048A); dlt('h8D,'hBF,2,-1); dlt('hC2,'hCE,2,-1);
                        fix('hCF,'h04C0); dlt('hD1,'hFF,2,-1);
                    end
                    'h05: begin dlt('h01,'h23,2,-1); dlt('h61,'h86,1,-48); end
                    'h1D: begin fix('h79,'hA77D); fix('h7D,'h2C63); end
                    'h1E: begin dlt('h01,'h95,2,-1); dlt('hA1,'hFF,2,-1); end
                    'h1F: begin
                        dlt('h00,'h07,1,8); dlt('h10,'h15,1,8); dlt('h20,'h27,1,8);
                        dlt('h30,'h37,1,8); dlt('h40,'h45,1,8); dlt('h51,'h57,2,8);
                        dlt('h60,'h67,1,8); dlt('h70,'h71,1,'h1FBA-'h1F70);
                        dlt('h72,'h75,1,'h1FC8-'h1F72); dlt('h76,'h77,1,'h1FDA-'h1F76);
                        dlt('h78,'h79,1,'h1FF8-'h1F78); dlt('h7A,'h7B,1,'h1FEA-'h1F7A);
                        dlt('h7C,'h7D,1,'h1FFA-'h1F7C); dlt('h80,'h87,1,8);
                        dlt('h90,'h97,1,8); dlt('hA0,'hA7,1,8); dlt('hB0,'hB1,1,8);
                        dlt('hB3,'hC3,16,9); dlt('hD0,'hD1,1,8); dlt('hE0,'hE1,1,8);
                        fix('hE5,'h1FEC); fix('hF3,'h1FFC);
                    end
                    'h21: begin fix('h4E,'h2132); dlt('h70,'h7F,1,-16); fix('h84,'h2183); end
                    'h24: dlt('hD0,'hE9,1,'h24B6-'h24D0);
                    'h2C: begin
                        dlt('h30,'h5E,1,-48); fix('h61,'h2C60); fix('h65,'h023A);
                        fix('h66,'h023E); dlt('h68,'h6C,2,-1); dlt('h73,'h76,3,-1);
                        dlt('h81,'hE3,2,-1);
                    end
                    'h2D: dlt('h00,'h25,1,'h10A0-'h2D00);
                    'hA6: begin dlt('h41,'h5F,2,-1); dlt('h63,'h6D,2,-1); dlt('h81,'h97,2,-1); end
                    'hA7: begin
                        dlt('h23,'h2F,2,-1); dlt('h33,'h6F,2,-1); dlt('h7A,'h7C,2,-1);
                        dlt('h7F,'h87,2,-1); fix('h8C,'hA78B);
                    end
                    'hFF: dlt('h41,'h5A,1,-32);
                    default: ;
                endcase
            end else begin
                case (pg)
                    'h00: begin dlt('h41,'h5A,1,32); dlt('hC0,'hD6,1,32); dlt('hD8,'hDE,1,32); end
                    'h01: begin
                        dlt('h00,'h2E,2,1); dlt('h32,'h36,2,1); dlt('h39,'h47,2,1);
                        dlt('h4A,'h76,2,1); fix('h78,'h00FF); dlt('h79,'h7D,2,1);
                        fix('h80,'h0243); fix('h81,'h0253); dlt('h82,'h84,2,1);
                        fix('h86,'h0254); dlt('h87,'h8B,4,1); dlt('h89,'h89,1,'h0256-'h0189);
                        fix('h8A,'h0257); fix('h8E,'h01DD); fix('h8F,'h0259);
                        fix('h90,'h025B); fix('h91,'h0192); fix('h93,'h0260);
                        fix('h94,'h0263); fix('h96,'h0269); fix('h97,'h0268);
                        fix('h98,'h0199); fix('h9C,'h026F); fix('h9D,'h0272);
                        fix('h9F,'h0275); dlt('hA0,'hA4,2,1); dlt('hA6,'hA9,3,'h0280-'h01A6);
                        fix('hAE,'h0288); dlt('hA7,'hAC,5,1); fix('hAF,'h01B0);
                        dlt('hB1,'hB2,1,'h028A-'h01B1); dlt('hB3,'hB5,2,1);
                        fix('hB7,'h0292); dlt('hB8,'hBC,4,1); dlt('hC4,'hCA,3,2);
                        dlt('hCD,'hDB,2,1); fix('hDE,'h01DF); dlt('hE0,'hEE,2,1);
                        fix('hF1,'h01F3); fix('hF4,'h01F5); fix('hF6,'h0195);
                        fix('hF7,'h01BF); dlt('hF8,'hFE,2,1);
                    end
                    'h02: begin
                        dlt('h00,'h1E,2,1); fix('h20,'h019E); dlt('h22,'h32,2,1);
                        fix('h3A,'h2C65); dlt('h3B,'h41,6,1); fix('h3D,'h019A);
                        fix('h3E,'h2C66); fix('h43,'h0180); fix('h44,'h0289);
                        fix('h45,'h028C); dlt('h46,'h4E,2,1);
                    end
                    'h03: begin
                        dlt('h70,'h72,2,1); fix('h76,'h0377); fix('h86,'h03AC);
                        dlt('h88,'h8A,1,'h03AD-'h0388); fix('h8C,'h03CC);
                        dlt('h8E,'h8F,1,63); dlt('h91,'hA1,1,32); dlt('hA3,'hA4,1,32);
                        dlt('hA5,'hAB,1,32); fix('hCF,'h03D7); dlt('hD8,'hEE,2,1);
                        fix('hF9,'h03F2); dlt('hF7,'hFA,3,1); dlt('hFD,'hFF,1,'h037B-'h03FD);
                    end
                    'h04: begin
                        dlt('h10,'h2F,1,32); dlt('h00,'h0F,1,80); dlt('h60,'h80,2,1);
                        fix('h8A,'h048B); dlt('h8C,'hBE,2,1); dlt('hC1,'hCD,2,1);
                        fix('hC0,'h04CF); dlt('hD0,'hFE,2,1);
                    end
                    'h05: begin dlt('h00,'h22,2,1); dlt('h31,'h56,1,48); end
                    'h10: dlt('hA0,'hC5,1,'h2D00-'h10A0);
                    'h1E: begin dlt('h00,'h94,2,1); dlt('hA0,'hFE,2,1); end
                    'h1F: begin
                        dlt('h08,'h0F,1,-8); dlt('h18,'h1D,1,-8); dlt('h28,'h2F,1,-8);
                        dlt('h38,'h3F,1,-8); dlt('h48,'h4D,1,-8); dlt('h59,'h5F,2,-8);
                        dlt('h68,'h6F,1,-8); dlt('hBA,'hBB,1,'h1F70-'h1FBA);
                        dlt('hC8,'hCB,1,'h1F72-'h1FC8); dlt('hDA,'hDB,1,'h1F76-'h1FDA);
                        dlt('hF8,'hF9,1,'h1F78-'h1FF8); dlt('hEA,'hEB,1,'h1F7A-'h1FEA);
                        dlt('hFA,'hFB,1,'h1F7C-'h1FFA); dlt('h88,'h8F,1,-8);
                        dlt('h98,'h9F,1,-8); dlt('hA8,'hAF,1,-8); dlt('hB8,'hB9,1,-8);
                        fix('hBB,'h1F71); dlt('hBC,'hCC,16,'h1FB3-'h1FBC);
                        dlt('hD8,'hD9,1,-8); dlt('hE8,'hE9,1,-8);
                        fix('hEC,'h1FE5); fix('hFC,'h1FF3);
                    end
                    'h21: begin fix('h32,'h214E); dlt('h60,'h6F,1,16); fix('h83,'h2184); end
                    'h24: dlt('hB6,'hCF,1,'h24D0-'h24B6);
                    'h2C: begin
                        dlt('h00,'h2E,1,48); fix('h60,'h2C61); dlt('h67,'h6B,2,1);
                        dlt('h72,'h75,3,1); dlt('h80,'hE2,2,1); fix('h62,'h026B);
                        fix('h63,'h1D7D); fix('h64,'h027D); fix('h6D,'h0251);
                        fix('h6E,'h0271); fix('h6F,'h0250);
                    end
                    'hA6: begin dlt('h40,'h5E,2,1); dlt('h62,'h6C,2,1); dlt('h80,'h96,2,1); end
                    'hA7: begin
                        dlt('h22,'h2E,2,1); dlt('h32,'h6E,2,1); dlt('h79,'h7B,2,1);
                        fix('h7D,'h1D79); dlt('h7E,'h86,2,1); fix('h8B,'hA78C);
                    end
                    'hFF: dlt('h21,'h3A,1,32);
                    default: ;
                endcase
            end
            return res;
        endfunction

        function void note_input(logic op, logic [CP_W-1:0] point);
            case_result_t e;
            e.opcode     = op;
            e.code_point = point;
            e.mapped     = map_case(op, point);
            e.changed    = (e.mapped != point);
            pending_maps.push_back(e);
        endfunction

        function void check_result(logic [CP_W-1:0] mapped, logic changed);
            case_result_t e;
            if (pending_maps.size() == 0) begin
                $display("%0t: result beat with nothing outstanding: cp %h changed %b",
                         $realtime, mapped, changed);
                errors++;
                return;
            end
            e = pending_maps.pop_front();
            if (mapped !== e.mapped) begin
                $display("%0t: op %b cp %h: mapped expected %h actual %h",
                         $realtime, e.opcode, e.code_point, e.mapped, mapped);
                errors++;
            end
            if (changed !== e.changed) begin
                $display("%0t: op %b cp %h: changed expected %b actual %b",
                         $realtime, e.opcode, e.code_point, e.changed, changed);
                errors++;
            end
        endfunction
    endclass

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    logic            s_opcode = OP_UPPER;
    logic [CP_W-1:0] s_code_point = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    logic [CP_W-1:0] m_mapped_code_point;
    logic            m_was_changed;

    case_map_scoreboard case_sb = new();
    bit                 no_idle = 1'b0;   // stretch with both sides running flat out

    // Pages that carry tables; most random beats land on one of them.
    int table_pages[] = '{'h00, 'h01, 'h02, 'h03, 'h04, 'h05, 'h10, 'h1D, 'h1E, 'h1F,
                          'h21, 'h24, 'h2C, 'h2D, 'hA6, 'hA7, 'hFF};

    always #5 aclk = ~aclk;

    unicode_case_mapper DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_opcode            (s_opcode),
        .s_code_point        (s_code_point),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_mapped_code_point (m_mapped_code_point),
        .m_was_changed       (m_was_changed)
    );

    // Beat monitor: values read here are those before the edge takes effect.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                case_sb.note_input(s_opcode, s_code_point);
            if (m_valid && m_ready)
                case_sb.check_result(m_mapped_code_point, m_was_changed);
        end
    end

    // Offer one code point; returns once the beat has been taken.
    task automatic send_code_point(logic op, logic [CP_W-1:0] point);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_code_point <= point;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [CP_W-1:0] random_code_point();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return CP_W'($urandom);                        // any 21-bit value, beyond 0x10FFFF too
        if (sel == 1)
            return CP_W'($urandom_range(0, 'h10FFFF));
        return CP_W'({table_pages[$urandom_range(0, table_pages.size() - 1)],
                      8'($urandom)});
    endfunction

    // Receiver: random stalls, never while the run is in a flat-out stretch.
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        logic [CP_W-1:0] directed[] = '{
            21'h000000, 21'h1FFFFF, 21'h10FFFF, 21'h110000, 21'h000061, 21'h000041,
            21'h0000FF, 21'h000178, 21'h000189, 21'h000256, 21'h0001AE, 21'h000280,
            21'h001FBB, 21'h001FB3, 21'h001FBC, 21'h001FC3, 21'h0024D0, 21'h0024B6,
            21'h0010A0, 21'h002D00, 21'h000250, 21'h0003CE, 21'h00A77D, 21'h00FF5A};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // both directions for every special case
        foreach (directed[i]) begin
            send_code_point(OP_UPPER, directed[i]);
            send_code_point(OP_LOWER, directed[i]);
        end

        for (int n = 0; n < 2000; n++) begin
            if (n % 400 == 200) no_idle = 1'b1;
            if (n % 400 == 300) no_idle = 1'b0;
            if (n == 1000) begin
                // drain the pipe completely before carrying on; wait on the clock edge first so
                // the last beat offered is already on the scoreboard
                s_valid <= 1'b0;
                @(posedge aclk);
                wait (case_sb.pending_maps.size() == 0);
                @(posedge aclk);
            end
            send_code_point(logic'($urandom_range(0, 1)), random_code_point());
        end
        s_valid <= 1'b0;
        no_idle = 1'b0;

        @(posedge aclk);
        wait (case_sb.pending_maps.size() == 0);
        repeat (10) @(posedge aclk);
        if (case_sb.errors == 0 && case_sb.pending_maps.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
